/* src/onset_pair_delay_with_outlier_reject_defines.svh */
// assertion macros shared by the onset pair delay block
// no dependencies; included by the top level
`ifndef ONSET_PAIR_DELAY_WITH_OUTLIER_REJECT_DEFINES_SVH
`define ONSET_PAIR_DELAY_WITH_OUTLIER_REJECT_DEFINES_SVH

// same-cycle implication under active-low reset
`define ODP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under active-low reset
`define ODP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/odp_pkg.sv */
// types, constants and codes for the onset pair delay block
// no dependencies; imported by every module of the block except odp_ram
`timescale 1ns / 1ps

package odp_pkg;

  localparam int MAX_ONSETS  = 32;
  localparam int IDX_W       = $clog2(MAX_ONSETS);
  localparam int CNT_W       = $clog2(MAX_ONSETS + 1);
  localparam int ONSET_W     = 24;
  localparam int DELAY_W     = 32;
  localparam int RATE_W      = 16;
  localparam int SUM_W       = DELAY_W + CNT_W;
  localparam int DIV_W       = 2 * DELAY_W + CNT_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int MS_SCALE    = 1000;
  localparam int KEEP_NUM    = 422;
  localparam int OK_DEV      = 50;
  localparam int OK_MEAN     = 3;
  localparam int MIN_KEPT    = 3;
  localparam int MIN_PAIRS   = 3;

  localparam logic [1:0] OP_LOAD_P = 2'd0;
  localparam logic [1:0] OP_LOAD_E = 2'd1;
  localparam logic [1:0] OP_RUN    = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD_P,
    CMD_LOAD_E,
    CMD_RUN
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FEW_PAIRS,
    ST_MEAN_ZERO,
    ST_FEW_KEPT
  } status_e;

  typedef struct packed {
    cmd_e                 op;
    logic [ONSET_W-1:0]   onset;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_t;

  typedef struct packed {
    logic                kind;
    logic [4:0]          entry_index;
    logic [DELAY_W-1:0]  delay_value;
    logic                delay_kept;
    logic [DELAY_W-1:0]  mean_delay;
    logic [DELAY_W-1:0]  delay_spread;
    logic                spread_ok;
    status_e             status;
    logic                last;
  } result_t;

endpackage

/* src/odp_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module odp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/odp_front.sv */
// input side: takes stream words, decodes the opcode and queues commands
// depends on odp_pkg
`timescale 1ns / 1ps

module odp_front import odp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [ONSET_W-1:0] onset_i,
  output queue_t             queue_o,
  input  logic               pop_i
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QC_W-1:0]  fill_q;
  logic             push;
  logic             do_pop;
  cmd_t             cmd;

  always_comb begin
    cmd.onset = onset_i;
    cmd.op    = CMD_RUN;
    push      = 1'b0;
    unique case (opcode_i)
      OP_LOAD_P: begin
        cmd.op = CMD_LOAD_P;
        push   = in_valid_i;
      end
      OP_LOAD_E: begin
        cmd.op = CMD_LOAD_E;
        push   = in_valid_i;
      end
      OP_RUN: begin
        cmd.op = CMD_RUN;
        push   = in_valid_i;
      end
      default: push = 1'b0;  // unused opcode is dropped
    endcase
  end

  assign in_ready_o    = (fill_q != QC_W'(QUEUE_DEPTH));
  assign do_pop        = pop_i && (fill_q != '0);
  assign queue_o.valid = (fill_q != '0);
  assign queue_o.cmd   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push && in_ready_o) begin
      slot_q[wr_ptr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push && in_ready_o) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      fill_q <= fill_q + QC_W'(push && in_ready_o) - QC_W'(do_pop);
    end
  end

endmodule

/* src/odp_div.sv */
// iterative restoring divider, one quotient bit per cycle
// depends on odp_pkg
`timescale 1ns / 1ps

module odp_div import odp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  dividend_i,
  input  logic [RATE_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DIV_W-1:0]  quot_o
);

  localparam int IT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  q_q;
  logic [RATE_W-1:0] rem_q;
  logic [RATE_W-1:0] dsr_q;
  logic [IT_W-1:0]   iter_q;
  logic              busy_q;
  logic [RATE_W:0]   shifted;
  logic              fits;

  assign shifted = {rem_q, q_q[DIV_W-1]};
  assign fits    = (shifted >= {1'b0, dsr_q});
  assign quot_o  = q_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      q_q   <= {q_q[DIV_W-2:0], fits};
      rem_q <= fits ? RATE_W'(shifted - {1'b0, dsr_q}) : shifted[RATE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= !start_i && busy_q && (iter_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= IT_W'(DIV_W - 1);
      end else if (busy_q) begin
        iter_q <= iter_q - 1'b1;
        if (iter_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

/* src/odp_sqrt.sv */
// iterative integer square root, one root bit per cycle
// depends on odp_pkg
`timescale 1ns / 1ps

module odp_sqrt import odp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [2*DELAY_W-1:0] rad_i,
  output logic                 done_o,
  output logic [DELAY_W-1:0]   root_o
);

  localparam int IT_W = $clog2(DELAY_W);

  logic [2*DELAY_W-1:0] x_q;
  logic [DELAY_W+1:0]   rem_q;
  logic [DELAY_W-1:0]   root_q;
  logic [IT_W-1:0]      iter_q;
  logic                 busy_q;
  logic [DELAY_W+1:0]   pulled;
  logic [DELAY_W+1:0]   trial;
  logic                 fits;

  assign pulled = {rem_q[DELAY_W-1:0], x_q[2*DELAY_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = (pulled >= trial);
  assign root_o = root_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[2*DELAY_W-3:0], 2'b00};
      rem_q  <= fits ? pulled - trial : pulled;
      root_q <= {root_q[DELAY_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= !start_i && busy_q && (iter_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= IT_W'(DELAY_W - 1);
      end else if (busy_q) begin
        iter_q <= iter_q - 1'b1;
        if (iter_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

/* src/odp_back.sv */
// execution side: onset stores, pairing walk, statistics, rejection, result output
// depends on odp_pkg, odp_ram, odp_div, odp_sqrt
`timescale 1ns / 1ps

module odp_back import odp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  queue_t            queue_i,
  output logic              pop_o,
  input  logic [RATE_W-1:0] rate_i,
  output result_t           res_o,
  output logic              res_valid_o,
  input  logic              res_ready_i
);

  typedef enum logic [4:0] {
    B_IDLE, B_M_CHK, B_M_RD, B_M_NXT_W, B_M_NXT, B_MUL, B_DIV, B_DIV_W, B_WR,
    B_PRE, B_SUM_A, B_SUM_B, B_MEAN, B_MEAN_W, B_SQ_A, B_SQ_B, B_SQ_C, B_SQ_D,
    B_VAR, B_VAR_W, B_SQRT_W, B_POST, B_REJ_A, B_REJ_B, B_REJ_END, B_EM_A, B_EM_B
  } state_e;

  state_e               state_q;
  logic [CNT_W-1:0]     pcnt_q, ecnt_q, pair_q, ti_q, ei_q, k_q, steps_q, i_q, n_q, kept_q;
  logic                 look_q, pass_q;
  logic [ONSET_W-1:0]   p_q, e_q;
  logic [ONSET_W+9:0]   prod_q;
  logic [DELAY_W-1:0]   dval_q, mean_q, dev_q, a_q;
  logic [2*DELAY_W-1:0] sq_q;
  logic [SUM_W-1:0]     sum_q;
  logic [DIV_W-1:0]     acc_q;
  logic [DELAY_W+8:0]   w_q;
  logic [DELAY_W+7:0]   m256_q;
  logic                 ok_q;
  status_e              status_q;
  logic [MAX_ONSETS-1:0] flag_q;

  logic [ONSET_W-1:0]   p_rdata, e_rdata;
  logic [DELAY_W-1:0]   d_rdata;
  logic                 we_p, we_e, we_d;
  logic [IDX_W-1:0]     e_raddr, i_idx;
  logic                 div_start, div_done, sqrt_done;
  logic [DIV_W-1:0]     div_dividend, div_quot;
  logic [RATE_W-1:0]    div_divisor;
  logic [DELAY_W-1:0]   root;
  logic                 pop;
  logic                 out_free;
  logic [DELAY_W+5:0]   dev50, mean3;
  logic [DELAY_W+8:0]   w_d;
  logic [DELAY_W+9:0]   lo_side, hi_side, d_lo, m_hi;
  logic [CNT_W-1:0]     ei_next;

  assign pop      = (state_q == B_IDLE) && queue_i.valid;
  assign pop_o    = pop;
  assign out_free = !res_valid_o || res_ready_i;
  assign i_idx    = i_q[IDX_W-1:0];
  assign ei_next  = ei_q + 1'b1;
  assign e_raddr  = look_q ? ei_next[IDX_W-1:0] : ei_q[IDX_W-1:0];

  assign we_p = pop && (queue_i.cmd.op == CMD_LOAD_P) && (pcnt_q < CNT_W'(MAX_ONSETS));
  assign we_e = pop && (queue_i.cmd.op == CMD_LOAD_E) && (ecnt_q < CNT_W'(MAX_ONSETS));
  assign we_d = (state_q == B_WR);

  odp_ram #(.WIDTH(ONSET_W), .DEPTH(MAX_ONSETS)) u_p_ram (
    .clk_i, .we_i(we_p), .waddr_i(pcnt_q[IDX_W-1:0]), .wdata_i(queue_i.cmd.onset),
    .raddr_i(ti_q[IDX_W-1:0]), .rdata_o(p_rdata)
  );

  odp_ram #(.WIDTH(ONSET_W), .DEPTH(MAX_ONSETS)) u_e_ram (
    .clk_i, .we_i(we_e), .waddr_i(ecnt_q[IDX_W-1:0]), .wdata_i(queue_i.cmd.onset),
    .raddr_i(e_raddr), .rdata_o(e_rdata)
  );

  odp_ram #(.WIDTH(DELAY_W), .DEPTH(MAX_ONSETS)) u_d_ram (
    .clk_i, .we_i(we_d), .waddr_i(pair_q[IDX_W-1:0]), .wdata_i(dval_q),
    .raddr_i(i_idx), .rdata_o(d_rdata)
  );

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_W'(prod_q);
    div_divisor  = rate_i;
    unique case (state_q)
      B_DIV: begin
        div_start = (rate_i != '0);
      end
      B_MEAN: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(sum_q);
        div_divisor  = RATE_W'(n_q);
      end
      B_VAR: begin
        div_start    = 1'b1;
        div_dividend = acc_q;
        div_divisor  = RATE_W'(n_q);
      end
      default: div_start = 1'b0;
    endcase
  end

  odp_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_dividend),
    .divisor_i(div_divisor), .done_o(div_done), .quot_o(div_quot)
  );

  odp_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i((state_q == B_VAR_W) && div_done),
    .rad_i(div_quot[2*DELAY_W-1:0]), .done_o(sqrt_done), .root_o(root)
  );

  always_comb begin
    dev50   = {6'b0, dev_q} * (DELAY_W+6)'(OK_DEV);
    mean3   = {6'b0, mean_q} * (DELAY_W+6)'(OK_MEAN);
    w_d     = {9'b0, dev_q} * (DELAY_W+9)'(KEEP_NUM);
    // keep window: d256 + w >= m256 and d256 <= m256 + w
    d_lo    = {2'b0, d_rdata, 8'b0};
    lo_side = d_lo + {1'b0, w_q};
    m_hi    = {2'b0, m256_q} + {1'b0, w_q};
    hi_side = {2'b0, m256_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      pcnt_q      <= '0;
      ecnt_q      <= '0;
      pair_q      <= '0;
      flag_q      <= '0;
      ti_q        <= '0;
      ei_q        <= '0;
      k_q         <= '0;
      steps_q     <= '0;
      i_q         <= '0;
      n_q         <= '0;
      kept_q      <= '0;
      look_q      <= 1'b0;
      pass_q      <= 1'b0;
      status_q    <= ST_OK;
      res_valid_o <= 1'b0;
    end else begin
      // the emit state sets valid itself
      if (res_valid_o && res_ready_i && (state_q != B_EM_B)) begin
        res_valid_o <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (pop) begin
            if (we_p) pcnt_q <= pcnt_q + 1'b1;
            if (we_e) ecnt_q <= ecnt_q + 1'b1;
            if (queue_i.cmd.op == CMD_RUN) begin
              ti_q    <= '0;
              ei_q    <= '0;
              k_q     <= '0;
              pair_q  <= '0;
              look_q  <= 1'b0;
              steps_q <= (pcnt_q > ecnt_q) ? pcnt_q : ecnt_q;
              state_q <= B_M_CHK;
            end
          end
        end
        B_M_CHK: begin
          if (k_q >= steps_q || ei_q >= ecnt_q || ti_q >= pcnt_q) begin
            state_q <= B_PRE;
          end else begin
            state_q <= B_M_RD;
          end
        end
        B_M_RD: begin
          p_q <= p_rdata;
          e_q <= e_rdata;
          if (p_rdata > e_rdata) begin
            if (ei_next == ecnt_q) begin
              state_q <= B_MUL;
            end else begin
              look_q  <= 1'b1;
              state_q <= B_M_NXT_W;
            end
          end else begin
            ti_q    <= ti_q + 1'b1;
            k_q     <= k_q + 1'b1;
            state_q <= B_M_CHK;
          end
        end
        B_M_NXT_W: state_q <= B_M_NXT;
        B_M_NXT: begin
          look_q <= 1'b0;
          if (p_q < e_rdata) begin
            state_q <= B_MUL;
          end else begin
            ei_q    <= ei_next;
            k_q     <= k_q + 1'b1;
            state_q <= B_M_CHK;
          end
        end
        B_MUL: begin
          prod_q  <= {10'b0, p_q - e_q} * (ONSET_W+10)'(MS_SCALE);
          state_q <= B_DIV;
        end
        B_DIV: begin
          if (rate_i == '0) begin
            dval_q  <= '1;
            state_q <= B_WR;
          end else begin
            state_q <= B_DIV_W;
          end
        end
        B_DIV_W: begin
          if (div_done) begin
            dval_q  <= (|div_quot[DIV_W-1:DELAY_W]) ? '1 : div_quot[DELAY_W-1:0];
            state_q <= B_WR;
          end
        end
        B_WR: begin
          flag_q[pair_q[IDX_W-1:0]] <= 1'b1;
          pair_q  <= pair_q + 1'b1;
          ti_q    <= ti_q + 1'b1;
          ei_q    <= ei_next;
          k_q     <= k_q + 1'b1;
          state_q <= B_M_CHK;
        end
        B_PRE: begin
          i_q <= '0;
          if (pair_q <= CNT_W'(MIN_PAIRS)) begin
            status_q <= ST_FEW_PAIRS;
            mean_q   <= '0;
            dev_q    <= '0;
            ok_q     <= 1'b0;
            state_q  <= B_EM_A;
          end else begin
            pass_q  <= 1'b0;
            sum_q   <= '0;
            n_q     <= '0;
            state_q <= B_SUM_A;
          end
        end
        B_SUM_A: begin
          state_q <= (i_q >= pair_q) ? B_MEAN : B_SUM_B;
        end
        B_SUM_B: begin
          if (flag_q[i_idx]) begin
            sum_q <= sum_q + SUM_W'(d_rdata);
            n_q   <= n_q + 1'b1;
          end
          i_q     <= i_q + 1'b1;
          state_q <= B_SUM_A;
        end
        B_MEAN: state_q <= B_MEAN_W;
        B_MEAN_W: begin
          if (div_done) begin
            mean_q  <= div_quot[DELAY_W-1:0];
            acc_q   <= '0;
            i_q     <= '0;
            state_q <= B_SQ_A;
          end
        end
        B_SQ_A: begin
          state_q <= (i_q >= pair_q) ? B_VAR : B_SQ_B;
        end
        B_SQ_B: begin
          a_q     <= (d_rdata >= mean_q) ? d_rdata - mean_q : mean_q - d_rdata;
          state_q <= B_SQ_C;
        end
        B_SQ_C: begin
          sq_q    <= a_q * a_q;
          state_q <= B_SQ_D;
        end
        B_SQ_D: begin
          if (flag_q[i_idx]) begin
            acc_q <= acc_q + DIV_W'(sq_q);
          end
          i_q     <= i_q + 1'b1;
          state_q <= B_SQ_A;
        end
        B_VAR: state_q <= B_VAR_W;
        B_VAR_W: begin
          if (div_done) state_q <= B_SQRT_W;
        end
        B_SQRT_W: begin
          if (sqrt_done) begin
            dev_q   <= root;
            state_q <= B_POST;
          end
        end
        B_POST: begin
          ok_q   <= (mean_q != '0) && (dev50 <= mean3);
          w_q    <= w_d;
          m256_q <= {mean_q, 8'b0};
          i_q    <= '0;
          kept_q <= '0;
          if (mean_q == '0) begin
            status_q <= ST_MEAN_ZERO;
            dev_q    <= '0;
            state_q  <= B_EM_A;
          end else if (pass_q) begin
            status_q <= ST_OK;
            state_q  <= B_EM_A;
          end else begin
            state_q <= B_REJ_A;
          end
        end
        B_REJ_A: begin
          state_q <= (i_q >= pair_q) ? B_REJ_END : B_REJ_B;
        end
        B_REJ_B: begin
          if (lo_side >= hi_side && d_lo <= m_hi) begin
            kept_q <= kept_q + 1'b1;
          end else begin
            flag_q[i_idx] <= 1'b0;
          end
          i_q     <= i_q + 1'b1;
          state_q <= B_REJ_A;
        end
        B_REJ_END: begin
          i_q <= '0;
          if (kept_q < CNT_W'(MIN_KEPT)) begin
            // first-pass figures are reported
            status_q <= ST_FEW_KEPT;
            state_q  <= B_EM_A;
          end else begin
            pass_q  <= 1'b1;
            sum_q   <= '0;
            n_q     <= '0;
            state_q <= B_SUM_A;
          end
        end
        B_EM_A: state_q <= B_EM_B;
        B_EM_B: begin
          if (out_free) begin
            res_valid_o        <= 1'b1;
            res_o.mean_delay   <= mean_q;
            res_o.delay_spread <= dev_q;
            res_o.spread_ok    <= ok_q;
            res_o.status       <= status_q;
            if (i_q == pair_q) begin
              res_o.kind        <= 1'b1;
              res_o.last        <= 1'b1;
              res_o.entry_index <= '0;
              res_o.delay_value <= '0;
              res_o.delay_kept  <= 1'b0;
              pcnt_q            <= '0;
              ecnt_q            <= '0;
              state_q           <= B_IDLE;
            end else begin
              res_o.kind        <= 1'b0;
              res_o.last        <= 1'b0;
              res_o.entry_index <= 5'(i_q);
              res_o.delay_value <= d_rdata;
              res_o.delay_kept  <= flag_q[i_idx];
              i_q               <= i_q + 1'b1;
              state_q           <= B_EM_A;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

/* src/onset_pair_delay_with_outlier_reject.sv */
// top level of the onset pair delay block: stream ports, rate register, assertions
// depends on odp_pkg, odp_front, odp_back and the block's defines header
//
// channel   dir  handshake                 contents
// s_axis    in   s_axis_tvalid/tready      tuser opcode, tdata onset time
// m_axis    out  m_axis_tvalid/tready      tuser kind, tlast, tdata result fields
// cfg       in   cfg_we_i                  sample rate, no read-back
//
// loads are written to the onset stores as the back end pops them; a four-word queue lets
// the input side go on taking words while a run is in progress, until the queue is full.
// a run walks the pairing steps; a step that yields a pair runs a 70-bit delay division
// (skipped for a zero rate), one bit per cycle. each statistics pass then sums the stored
// delays and their squared deviations and runs its divisions and root; rejection checks
// each delay against the keep window. results then leave one word at a time through
// B_EM_A and B_EM_B; output stalls hold the back end.
// reset clears counts, flags and handshake state; onset and delay stores are not cleared.
`timescale 1ns / 1ps
`include "onset_pair_delay_with_outlier_reject_defines.svh"

module onset_pair_delay_with_outlier_reject import odp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [23:0]   s_axis_tdata,   // onset_time
  input  logic [1:0]    s_axis_tuser,   // opcode
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // entry_index, delay_value, delay_kept, mean_delay, delay_spread, spread_ok,
  // status, zero fill
  output logic [111:0]  m_axis_tdata,
  output logic [0:0]    m_axis_tuser,   // kind
  output logic          m_axis_tlast,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i
);

  logic [RATE_W-1:0] rate_q;
  queue_t            queue;
  logic              pop;
  result_t           res;
  logic              few_pairs, zero_stats, few_entry, stats_clear, run_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_W'(1024);
    end else if (cfg_we_i) begin
      rate_q <= cfg_wdata_i;
    end
  end

  odp_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .opcode_i(s_axis_tuser), .onset_i(s_axis_tdata),
    .queue_o(queue), .pop_i(pop)
  );

  odp_back u_back (
    .clk_i, .rst_ni,
    .queue_i(queue), .pop_o(pop), .rate_i(rate_q),
    .res_o(res), .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {7'b0, res.status, res.spread_ok, res.delay_spread, res.mean_delay,
                         res.delay_kept, res.delay_value, res.entry_index};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

  assign few_pairs   = (res.status == ST_FEW_PAIRS);
  assign zero_stats  = few_pairs || (res.status == ST_MEAN_ZERO);
  assign few_entry   = few_pairs && !res.last;
  assign stats_clear = (m_axis_tdata[102:38] == '0);
  assign run_done    = m_axis_tvalid && m_axis_tready && m_axis_tlast;

  `ODP_ASSERT_IMPLY(a_kind_last, clk_i, rst_ni, m_axis_tvalid, res.kind == res.last, "kind vs last")
  `ODP_ASSERT_IMPLY(a_few_zero, clk_i, rst_ni, m_axis_tvalid && zero_stats, stats_clear, "stats set")
  `ODP_ASSERT_IMPLY(a_few_kept, clk_i, rst_ni, m_axis_tvalid && few_entry, res.delay_kept, "dropped")
  `ODP_ASSERT_NEXT(a_gap_after_run, clk_i, rst_ni, run_done, !m_axis_tvalid, "word after summary")

endmodule
